[rtl/core/rtd_pkg.sv]
// Shared types, constants and helpers for the resize target dimension block
`default_nettype none

package rtd_pkg;

   localparam int DIM_BITS     = 14;
   localparam int OUT_BITS     = 16;
   localparam int PROD_BITS    = 2 * DIM_BITS;
   localparam int WIDE_BITS    = PROD_BITS + 1;
   localparam int CSR_IDX_BITS = 3;

   typedef logic [DIM_BITS-1:0]     dim_type;
   typedef logic [PROD_BITS-1:0]    prod_type;
   typedef logic [WIDE_BITS-1:0]    wide_type;
   typedef logic [OUT_BITS-1:0]     out_type;
   typedef logic [CSR_IDX_BITS-1:0] csr_idx_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_USER_WIDTH  = 3'd0,
      CSR_USER_HEIGHT = 3'd1,
      CSR_MIN_SIDE    = 3'd2,
      CSR_MAX_SIDE    = 3'd3,
      CSR_CROP_ENABLE = 3'd4
   } csr_reg_type;

   typedef struct packed {
      dim_type user_width;
      dim_type user_height;
      dim_type min_side;
      dim_type max_side;
      logic    crop_enable;
   } cfg_type;

   typedef struct packed {
      logic    need_div;
      logic    div_is_width;
      dim_type fix_w;
      dim_type fix_h;
   } side_type;

   typedef struct packed {
      dim_type  rem;
      prod_type work;
      dim_type  den;
      side_type side;
   } cell_type;

   // floor at 1, saturate at the all-ones output code
   function automatic out_type finish_side(wide_type v);
      logic over;
      over = 1'b0;
      for (int i = OUT_BITS; i < WIDE_BITS; i++) begin
         over = over | v[i];
      end
      if (v == '0) begin
         return out_type'(1);
      end else if (over) begin
         return '1;
      end else begin
         return out_type'(v);
      end
   endfunction

endpackage

`default_nettype wire

[rtl/core/rtd_front.sv]
// Front stages: clamp the source, crop products, mode select, scale product
`default_nettype none

module rtd_front
   import rtd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     in_valid,
   output logic     in_ready,
   input  dim_type  in_sw,
   input  dim_type  in_sh,
   output logic     out_valid,
   input  logic     out_ready,
   output cell_type out_data
);

   logic     s1_valid_ff;
   dim_type  s1_sw_ff, s1_sh_ff;
   prod_type s1_p1_ff, s1_p2_ff;
   dim_type  s1_sw_in, s1_sh_in;
   prod_type s1_p1_in, s1_p2_in;

   logic     s2_valid_ff;
   dim_type  s2_a_ff, s2_b_ff, s2_den_ff;
   side_type s2_side_ff;
   dim_type  s2_a_in, s2_b_in, s2_den_in;
   side_type s2_side_in;

   logic     s3_valid_ff;
   cell_type s3_data_ff;
   cell_type s3_data_in;

   logic s1_ready, s2_ready, s3_ready;
   logic land;

   assign s3_ready  = !s3_valid_ff || out_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign in_ready  = s1_ready;
   assign out_valid = s3_valid_ff;
   assign out_data  = s3_data_ff;

   always_comb begin
      s1_sw_in = (in_sw == '0) ? dim_type'(1) : in_sw;
      s1_sh_in = (in_sh == '0) ? dim_type'(1) : in_sh;
      s1_p1_in = prod_type'(s1_sh_in) * prod_type'(cfg.user_width);
      s1_p2_in = prod_type'(cfg.user_height) * prod_type'(s1_sw_in);
   end

   assign land = s1_sw_ff > s1_sh_ff;

   always_comb begin
      s2_side_in.need_div     = 1'b0;
      s2_side_in.div_is_width = 1'b0;
      s2_side_in.fix_w        = s1_sw_ff;
      s2_side_in.fix_h        = s1_sh_ff;
      s2_b_in                 = '0;
      priority if (cfg.user_width == '0 && cfg.user_height == '0) begin
         priority if (cfg.min_side != '0 && cfg.max_side == '0) begin
            s2_side_in.need_div     = 1'b1;
            s2_side_in.div_is_width = land;
            s2_b_in                 = cfg.min_side;
         end else if (cfg.min_side == '0 && cfg.max_side != '0) begin
            s2_side_in.need_div     = 1'b1;
            s2_side_in.div_is_width = !land;
            s2_b_in                 = cfg.max_side;
         end else if (cfg.min_side != '0 && cfg.max_side != '0) begin
            s2_side_in.fix_w = land ? cfg.max_side : cfg.min_side;
            s2_side_in.fix_h = land ? cfg.min_side : cfg.max_side;
         end else begin
            s2_side_in.need_div = 1'b0;
         end
      end else if (cfg.user_height == '0) begin
         s2_side_in.need_div = 1'b1;
         s2_b_in             = cfg.user_width;
      end else if (cfg.user_width == '0) begin
         s2_side_in.need_div     = 1'b1;
         s2_side_in.div_is_width = 1'b1;
         s2_b_in                 = cfg.user_height;
      end else if (!cfg.crop_enable) begin
         s2_side_in.fix_w = cfg.user_width;
         s2_side_in.fix_h = cfg.user_height;
      end else if (s1_p1_ff < s1_p2_ff) begin
         s2_side_in.need_div     = 1'b1;
         s2_side_in.div_is_width = 1'b1;
         s2_b_in                 = cfg.user_height;
      end else begin
         s2_side_in.need_div = 1'b1;
         s2_b_in             = cfg.user_width;
      end
      if (s2_side_in.need_div) begin
         if (s2_side_in.div_is_width) begin
            s2_side_in.fix_h = s2_b_in;
         end else begin
            s2_side_in.fix_w = s2_b_in;
         end
      end
      if (!s2_side_in.need_div) begin
         s2_a_in   = '0;
         s2_den_in = dim_type'(1);
      end else if (s2_side_in.div_is_width) begin
         s2_a_in   = s1_sw_ff;
         s2_den_in = s1_sh_ff;
      end else begin
         s2_a_in   = s1_sh_ff;
         s2_den_in = s1_sw_ff;
      end
   end

   always_comb begin
      s3_data_in.rem  = '0;
      s3_data_in.work = prod_type'(s2_a_ff) * prod_type'(s2_b_ff);
      s3_data_in.den  = s2_den_ff;
      s3_data_in.side = s2_side_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_sw_ff <= s1_sw_in;
         s1_sh_ff <= s1_sh_in;
         s1_p1_ff <= s1_p1_in;
         s1_p2_ff <= s1_p2_in;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_a_ff    <= s2_a_in;
         s2_b_ff    <= s2_b_in;
         s2_den_ff  <= s2_den_in;
         s2_side_ff <= s2_side_in;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_data_ff <= s3_data_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/rtd_div_cell.sv]
// One restoring division cell: one quotient bit per cell
`default_nettype none

module rtd_div_cell
   import rtd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  cell_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output cell_type out_data
);

   logic                valid_ff;
   cell_type            data_ff;
   cell_type            data_in;
   logic [DIM_BITS:0]   shifted;
   logic [DIM_BITS:0]   den_ext;
   logic                ge;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      shifted = {in_data.rem, in_data.work[PROD_BITS-1]};
      den_ext = {1'b0, in_data.den};
      ge      = shifted >= den_ext;
      data_in      = in_data;
      data_in.rem  = ge ? DIM_BITS'(shifted - den_ext) : DIM_BITS'(shifted);
      data_in.work = {in_data.work[PROD_BITS-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/rtd_back.sv]
// Rounding, floor and saturation, and the result register
`default_nettype none

module rtd_back
   import rtd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  cell_type in_data,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output out_type  rsp_target_width,
   output out_type  rsp_target_height
);

   logic    rsp_valid_ff;
   out_type tw_ff, th_ff;
   out_type tw_in, th_in;
   logic    round_up;
   wide_type rounded;
   out_type scaled, fw, fh;

   assign in_ready          = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_target_width  = tw_ff;
   assign rsp_target_height = th_ff;

   always_comb begin
      round_up = {in_data.rem, 1'b0} >= {1'b0, in_data.den};
      rounded  = {1'b0, in_data.work} + wide_type'(round_up);
      scaled   = finish_side(rounded);
      fw       = finish_side(wide_type'(in_data.side.fix_w));
      fh       = finish_side(wide_type'(in_data.side.fix_h));
      tw_in    = (in_data.side.need_div && in_data.side.div_is_width) ? scaled : fw;
      th_in    = (in_data.side.need_div && !in_data.side.div_is_width) ? scaled : fh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (in_ready) begin
         rsp_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         tw_ff <= tw_in;
         th_ff <= th_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/resize_target_dimensions.sv]
// Top level: scaler output size from source frame size and configuration
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid, req_stall  | req_source_width, req_source_height
//   rsp     | out       | rsp_valid, rsp_stall  | rsp_target_width, rsp_target_height
//   csr     | in        | csr_valid, csr_ready  | csr_index, csr_data
//
// One item per cycle sustained while rsp_stall is low; each item passes the front stages,
// the row of restoring division cells, one quotient bit per cell, and the result register.
// Every stage holds an item and moves on when the next stage is empty or moving,
// so bubbles close up and items enter while a result waits under rsp_stall.
// Reset clears all valid bits and the configuration registers; csr_ready is always high.
`default_nettype none

module resize_target_dimensions
   import rtd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  dim_type     req_source_width,
   input  dim_type     req_source_height,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output out_type     rsp_target_width,
   output out_type     rsp_target_height,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  csr_idx_type csr_index,
   input  dim_type     csr_data
);

   cfg_type  cfg_ff;
   logic     front_ready;
   logic     chain_valid [PROD_BITS+1];
   logic     chain_ready [PROD_BITS+1];
   cell_type chain_data  [PROD_BITS+1];

   assign csr_ready = 1'b1;
   assign req_stall = !front_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_USER_WIDTH:  cfg_ff.user_width  <= csr_data;
            CSR_USER_HEIGHT: cfg_ff.user_height <= csr_data;
            CSR_MIN_SIDE:    cfg_ff.min_side    <= csr_data;
            CSR_MAX_SIDE:    cfg_ff.max_side    <= csr_data;
            CSR_CROP_ENABLE: cfg_ff.crop_enable <= csr_data[0];
            default: ;
         endcase
      end
   end

   rtd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .in_sw     (req_source_width),
      .in_sh     (req_source_height),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   for (genvar g = 0; g < PROD_BITS; g++) begin : g_cell
      rtd_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[g]),
         .in_ready  (chain_ready[g]),
         .in_data   (chain_data[g]),
         .out_valid (chain_valid[g+1]),
         .out_ready (chain_ready[g+1]),
         .out_data  (chain_data[g+1])
      );
   end

   rtd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (chain_valid[PROD_BITS]),
      .in_ready          (chain_ready[PROD_BITS]),
      .in_data           (chain_data[PROD_BITS]),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_target_width  (rsp_target_width),
      .rsp_target_height (rsp_target_height)
   );

endmodule

`default_nettype wire
